FILE: rtl/plsrgb_pkg.sv
// ----------------------------------------------------------------------------
// plsrgb_pkg
// Types, constants and the sRGB threshold table of the premultiplied
// linear to 8-bit sRGB converter.
// ----------------------------------------------------------------------------
package plsrgb_pkg;

    localparam int IN_W          = 16;
    localparam int FRAC_BITS_DEF = 12;
    localparam int OUT_BITS      = 8;
    localparam int QUOT_BITS     = 16;
    localparam int V_W           = QUOT_BITS + 1;
    localparam int CODE_MAX      = (1 << OUT_BITS) - 1;
    localparam int DIV_STEPS     = 4;
    localparam int BIG_W         = 384;

    typedef struct packed {
        logic signed [IN_W-1:0] red_linear;
        logic signed [IN_W-1:0] green_linear;
        logic signed [IN_W-1:0] blue_linear;
        logic signed [IN_W-1:0] alpha_linear;
        logic                   frame_end_in;
    } linear_pixel_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] red_srgb;
        logic [OUT_BITS-1:0] green_srgb;
        logic [OUT_BITS-1:0] blue_srgb;
        logic [OUT_BITS-1:0] alpha_byte;
        logic                frame_end_out;
    } srgb_pixel_t;

    typedef logic [V_W-1:0] thresh_tab_t [0:CODE_MAX];

    // True when quotient v (QUOT_BITS fraction bits) encodes to code k or above.
    function automatic logic reaches(input longint v, input longint k);
        longint           odd;
        logic [BIG_W-1:0] lhs;
        logic [BIG_W-1:0] rhs;
        logic [BIG_W-1:0] num;
        logic [BIG_W-1:0] den;
        logic [BIG_W-1:0] vb;
        logic             res;
        odd = 2 * k - 1;
        if (v * 10000000 <= (longint'(31308) << QUOT_BITS)) begin
            res = (v * 1292 * 2 * CODE_MAX) >= (odd * 100 * (longint'(1) << QUOT_BITS));
        end
        else begin
            num = BIG_W'(odd * 1000 + 110 * CODE_MAX);
            den = BIG_W'(2110 * CODE_MAX);
            vb  = BIG_W'(v);
            lhs = BIG_W'(1);
            rhs = BIG_W'(1);
            for (int i = 0; i < 5; i++) begin
                lhs = lhs * vb;
                rhs = rhs << QUOT_BITS;
            end
            for (int i = 0; i < 12; i++) begin
                lhs = lhs * den;
                rhs = rhs * num;
            end
            res = (lhs >= rhs);
        end
        return res;
    endfunction

    // Smallest quotient that reaches each code; the encoding rises with v.
    function automatic thresh_tab_t build_thresh();
        thresh_tab_t tab;
        longint      lo;
        longint      hi;
        longint      mid;
        tab[0] = '0;
        for (int k = 1; k <= CODE_MAX; k++) begin
            lo = 0;
            hi = longint'(1) << QUOT_BITS;
            while (lo < hi) begin
                mid = (lo + hi) >> 1;
                if (reaches(mid, longint'(k))) begin
                    hi = mid;
                end
                else begin
                    lo = mid + 1;
                end
            end
            tab[k] = V_W'(lo);
        end
        return tab;
    endfunction

    localparam thresh_tab_t THRESH_TAB = build_thresh();

endpackage

FILE: rtl/premultiplied_linear_to_srgb8_core.sv
// ----------------------------------------------------------------------------
// premultiplied_linear_to_srgb8_core
// Converts premultiplied linear RGBA pixels to straight-alpha sRGB bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on linear_valid / linear_stall / linear_pixel and leave on
//   srgb_valid / srgb_stall / srgb_pixel. A request moves on an edge where
//   valid is high and stall is low.
//   Alpha is clamped to [0,1]; each color is divided by nonzero alpha in a
//   restoring divider of QUOT_BITS steps, DIV_STEPS per stage, then coded by
//   a bitwise search of the sRGB threshold table, one code bit per stage.
//   Throughput: one pixel per cycle unless stalled; each stage holds one.
//   Reset clears all valid bits; no table fill is needed.
//   While srgb_stall holds a valid result, the whole pipeline freezes and
//   linear_stall is raised; nothing is dropped or repeated. Bubbles move on.
// ----------------------------------------------------------------------------
module premultiplied_linear_to_srgb8_core
    import plsrgb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          linear_valid,
    output logic          linear_stall,
    input  linear_pixel_t linear_pixel,
    output logic          srgb_valid,
    input  logic          srgb_stall,
    output srgb_pixel_t   srgb_pixel
);

    localparam int AW     = FRAC_BITS + 1;
    localparam int RW     = FRAC_BITS + 2;
    localparam int DS     = QUOT_BITS / DIV_STEPS;
    localparam int NS     = 1 + DS + OUT_BITS;
    localparam int CMP_W  = IN_W + 2;
    localparam int AB_W   = AW + OUT_BITS + 2;

    logic advance;

    logic                valid_reg   [0:NS-1];
    logic [OUT_BITS-1:0] abyte_reg   [0:NS-1];
    logic                fe_reg      [0:NS-1];

    // divider section: index 0 is the front stage
    logic [AW-1:0]        a_reg   [0:DS];
    logic [AW-1:0]        rem_reg [0:DS][0:2];
    logic [QUOT_BITS-1:0] q_reg   [0:DS][0:2];
    logic                 byp_reg [0:DS][0:2];
    logic [V_W-1:0]       bv_reg  [0:DS][0:2];

    // encoder section
    logic [V_W-1:0]      v_reg    [0:OUT_BITS-1][0:2];
    logic [OUT_BITS-1:0] code_reg [0:OUT_BITS-1][0:2];

    assign srgb_valid   = valid_reg[NS-1];
    assign advance      = !valid_reg[NS-1] || !srgb_stall;
    assign linear_stall = !advance;

    // ---------------- front stage: clamp alpha, classify colors ----------------
    logic signed [CMP_W-1:0] alpha_ext;
    logic [AW-1:0]           a_next;
    logic [AB_W-1:0]         ab_sum;
    logic [OUT_BITS-1:0]     abyte_next;
    logic signed [IN_W-1:0]  chan_in [0:2];
    logic [AW-1:0]           rem_next [0:2];
    logic                    byp_next [0:2];
    logic [V_W-1:0]          bv_next  [0:2];

    assign chan_in[0] = linear_pixel.red_linear;
    assign chan_in[1] = linear_pixel.green_linear;
    assign chan_in[2] = linear_pixel.blue_linear;

    always_comb
    begin
        logic signed [CMP_W-1:0] c_ext;
        logic signed [CMP_W-1:0] one_ext;
        alpha_ext = CMP_W'(linear_pixel.alpha_linear);
        one_ext   = CMP_W'(1) <<< FRAC_BITS;
        if (alpha_ext < 0) begin
            a_next = '0;
        end
        else if (alpha_ext > one_ext) begin
            a_next = AW'(1) << FRAC_BITS;
        end
        else begin
            a_next = AW'(alpha_ext);
        end
        ab_sum     = AB_W'(a_next) * AB_W'(CODE_MAX) * AB_W'(2) + (AB_W'(1) << FRAC_BITS);
        abyte_next = ab_sum[FRAC_BITS+1 +: OUT_BITS];
        for (int ch = 0; ch < 3; ch++) begin
            c_ext        = CMP_W'(chan_in[ch]);
            rem_next[ch] = '0;
            byp_next[ch] = 1'b1;
            bv_next[ch]  = '0;
            if (a_next != '0) begin
                if (c_ext <= 0) begin
                    bv_next[ch] = '0;
                end
                else if (c_ext >= CMP_W'(a_next)) begin
                    bv_next[ch] = V_W'(1) << QUOT_BITS;
                end
                else begin
                    byp_next[ch] = 1'b0;
                    rem_next[ch] = AW'(c_ext);
                end
            end
            else if (c_ext <= 0) begin
                bv_next[ch] = '0;
            end
            else if (c_ext >= one_ext) begin
                bv_next[ch] = V_W'(1) << QUOT_BITS;
            end
            else begin
                bv_next[ch] = V_W'(c_ext) << (QUOT_BITS - FRAC_BITS);
            end
        end
    end

    // control registers of every stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int s = 0; s < NS; s++) begin
                valid_reg[s] <= 1'b0;
            end
        end
        else if (advance) begin
            valid_reg[0] <= linear_valid;
            for (int s = 1; s < NS; s++) begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    // pass-through payload
    always_ff @(posedge clk)
    begin
        if (advance) begin
            abyte_reg[0] <= abyte_next;
            fe_reg[0]    <= linear_pixel.frame_end_in;
            for (int s = 1; s < NS; s++) begin
                abyte_reg[s] <= abyte_reg[s-1];
                fe_reg[s]    <= fe_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            a_reg[0] <= a_next;
            for (int ch = 0; ch < 3; ch++) begin
                rem_reg[0][ch] <= rem_next[ch];
                q_reg[0][ch]   <= '0;
                byp_reg[0][ch] <= byp_next[ch];
                bv_reg[0][ch]  <= bv_next[ch];
            end
        end
    end

    // ---------------- divider stages ----------------
    for (genvar d = 1; d <= DS; d++) begin : g_div
        logic [AW-1:0]        rem_d [0:2];
        logic [QUOT_BITS-1:0] q_d   [0:2];

        always_comb
        begin
            logic [RW-1:0] trial;
            for (int ch = 0; ch < 3; ch++) begin
                rem_d[ch] = rem_reg[d-1][ch];
                q_d[ch]   = q_reg[d-1][ch];
                for (int i = 0; i < DIV_STEPS; i++) begin
                    trial = {rem_d[ch], 1'b0};
                    if (trial >= RW'(a_reg[d-1])) begin
                        rem_d[ch] = AW'(trial - RW'(a_reg[d-1]));
                        q_d[ch]   = {q_d[ch][QUOT_BITS-2:0], 1'b1};
                    end
                    else begin
                        rem_d[ch] = AW'(trial);
                        q_d[ch]   = {q_d[ch][QUOT_BITS-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance) begin
                a_reg[d] <= a_reg[d-1];
                for (int ch = 0; ch < 3; ch++) begin
                    rem_reg[d][ch] <= rem_d[ch];
                    q_reg[d][ch]   <= q_d[ch];
                    byp_reg[d][ch] <= byp_reg[d-1][ch];
                    bv_reg[d][ch]  <= bv_reg[d-1][ch];
                end
            end
        end
    end

    // ---------------- encoder stages: one code bit each ----------------
    for (genvar e = 0; e < OUT_BITS; e++) begin : g_enc
        localparam int B = OUT_BITS - 1 - e;
        logic [V_W-1:0]      v_in    [0:2];
        logic [OUT_BITS-1:0] code_in [0:2];
        logic [OUT_BITS-1:0] code_e  [0:2];

        always_comb
        begin
            logic [OUT_BITS-1:0] cand;
            for (int ch = 0; ch < 3; ch++) begin
                if (e == 0) begin
                    v_in[ch]    = byp_reg[DS][ch] ? bv_reg[DS][ch] : V_W'(q_reg[DS][ch]);
                    code_in[ch] = '0;
                end
                else begin
                    v_in[ch]    = v_reg[(e == 0) ? 0 : e-1][ch];
                    code_in[ch] = code_reg[(e == 0) ? 0 : e-1][ch];
                end
                cand = code_in[ch] | (OUT_BITS'(1) << B);
                if (THRESH_TAB[cand] <= v_in[ch]) begin
                    code_e[ch] = cand;
                end
                else begin
                    code_e[ch] = code_in[ch];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance) begin
                for (int ch = 0; ch < 3; ch++) begin
                    v_reg[e][ch]    <= v_in[ch];
                    code_reg[e][ch] <= code_e[ch];
                end
            end
        end
    end

    assign srgb_pixel.red_srgb      = code_reg[OUT_BITS-1][0];
    assign srgb_pixel.green_srgb    = code_reg[OUT_BITS-1][1];
    assign srgb_pixel.blue_srgb     = code_reg[OUT_BITS-1][2];
    assign srgb_pixel.alpha_byte    = abyte_reg[NS-1];
    assign srgb_pixel.frame_end_out = fe_reg[NS-1];

endmodule

FILE: verif/premultiplied_linear_to_srgb8_core_test.sv
// ----------------------------------------------------------------------------
// premultiplied_linear_to_srgb8_core_test
// Drives premultiplied linear RGBA pixels through the converter with random
// idle and stall, predicts each sRGB pixel with an exact curve model or a
// fixed table value, and compares every field of every result in order.
// ----------------------------------------------------------------------------
module premultiplied_linear_to_srgb8_core_test;
    import plsrgb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC          = FRAC_BITS_DEF;
    localparam int ONE           = 1 << FRAC;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int QUIET_LO      = 600;
    localparam int QUIET_HI      = 900;
    localparam int IDLE_PCT      = 30;
    localparam int DRAIN_CYCLES  = 40;
    localparam int STUCK_LIMIT   = 5000;
    localparam int DIRECTED_ROWS = 18;

    typedef struct {
        linear_pixel_t px;
        bit            has_fixed;
        srgb_pixel_t   fixed_out;
    } request_t;

    typedef struct packed {
        int r;
        int g;
        int b;
        int a;
        bit fe;
        bit has_fixed;
        int code;
        int alpha_code;
    } row_t;

    //        red     green   blue    alpha   fe  fixed code alpha
    localparam row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
        '{0,      0,      0,      0,      1'b0, 1'b1,   0,   0},
        '{ONE,    ONE,    ONE,    ONE,    1'b1, 1'b1, 255, 255},
        '{-32768, -32768, -32768, ONE,    1'b0, 1'b1,   0, 255},
        '{ONE,    ONE,    ONE,    -32768, 1'b0, 1'b1, 255,   0},
        '{32767,  32767,  32767,  100,    1'b1, 1'b1, 255,   6},
        '{32767,  32767,  32767,  32767,  1'b0, 1'b1, 255, 255},
        '{32767,  32767,  32767,  0,      1'b0, 1'b1, 255,   0},
        '{-1,     -1,     -1,     -1,     1'b1, 1'b1,   0,   0},
        // curve junction, undivided and divided
        '{12,     13,     14,     0,      1'b0, 1'b0,   0,   0},
        '{12,     13,     205,    ONE,    1'b0, 1'b0,   0,   0},
        '{1,      2,      3,      ONE,    1'b0, 1'b0,   0,   0},
        '{1,      1,      1,      1,      1'b0, 1'b0,   0,   0},
        '{1000,   2000,   3000,   ONE/2,  1'b1, 1'b0,   0,   0},
        '{2047,   2048,   2049,   2048,   1'b0, 1'b0,   0,   0},
        '{-5,     7,      ONE+1,  3,      1'b0, 1'b0,   0,   0},
        '{700,    1500,   2800,   0,      1'b1, 1'b0,   0,   0},
        '{1,      100,    4095,   4095,   1'b0, 1'b0,   0,   0},
        '{-32768, 21845,  -21846, 4097,   1'b1, 1'b0,   0,   0}
    };

    logic          clk;
    logic          rst_n;
    logic          linear_valid;
    logic          linear_stall;
    linear_pixel_t linear_pixel;
    logic          srgb_valid;
    logic          srgb_stall;
    srgb_pixel_t   srgb_pixel;

    request_t    requests[$];
    srgb_pixel_t pending_pixels[$];
    request_t    cur_req;
    int          next_req = 0;
    int          accepted_cnt = 0;
    int          out_cnt = 0;
    int          errors = 0;
    int          stuck_cycles;

    premultiplied_linear_to_srgb8_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .linear_valid (linear_valid),
        .linear_stall (linear_stall),
        .linear_pixel (linear_pixel),
        .srgb_valid   (srgb_valid),
        .srgb_stall   (srgb_stall),
        .srgb_pixel   (srgb_pixel)
    );

    always #10 clk = ~clk;

    // True when quotient q (16 fraction bits) encodes to code k or above.
    function automatic bit code_at_least(input longint q, input longint k);
        longint       odd;
        logic [415:0] lhs;
        logic [415:0] rhs;
        logic [415:0] num;
        logic [415:0] den;
        odd = 2 * k - 1;
        if (q * 10000000 <= (longint'(31308) << QUOT_BITS))
            return (q * 1292 * 2 * CODE_MAX) >= (odd * 100 * (longint'(1) << QUOT_BITS));
        num = 416'(odd * 1000 + 110 * CODE_MAX);
        den = 416'(2110 * CODE_MAX);
        lhs = 416'(1);
        rhs = 416'(1) << (5 * QUOT_BITS);
        for (int i = 0; i < 5; i++)
            lhs = lhs * 416'(q);
        for (int i = 0; i < 12; i++)
        begin
            lhs = lhs * den;
            rhs = rhs * num;
        end
        return lhs >= rhs;
    endfunction

    function automatic logic [OUT_BITS-1:0] srgb_code(input longint q);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = CODE_MAX;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (code_at_least(q, longint'(mid)))
                lo = mid;
            else
                hi = mid - 1;
        end
        return OUT_BITS'(lo);
    endfunction

    function automatic logic [OUT_BITS-1:0] channel_code(input int c, input int a);
        longint q;
        if (a > 0)
        begin
            q = (c <= 0) ? 0 : (longint'(c) << QUOT_BITS) / a;
            if (q > (longint'(1) << QUOT_BITS))
                q = longint'(1) << QUOT_BITS;
        end
        else
        begin
            if (c < 0)
                c = 0;
            if (c > ONE)
                c = ONE;
            q = longint'(c) << (QUOT_BITS - FRAC);
        end
        return srgb_code(q);
    endfunction

    function automatic srgb_pixel_t unpremultiply_encode(input linear_pixel_t px);
        srgb_pixel_t res;
        int          a;
        a = int'(px.alpha_linear);
        if (a < 0)
            a = 0;
        if (a > ONE)
            a = ONE;
        res.red_srgb      = channel_code(int'(px.red_linear), a);
        res.green_srgb    = channel_code(int'(px.green_linear), a);
        res.blue_srgb     = channel_code(int'(px.blue_linear), a);
        res.alpha_byte    = OUT_BITS'((longint'(a) * CODE_MAX * 2 + ONE) >> (FRAC + 1));
        res.frame_end_out = px.frame_end_in;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch on pixel %0d: %s got %0d, want %0d", out_cnt, field, got, want);
        errors++;
    endtask

    task automatic add_row(input int r, input int g, input int b, input int a, input bit fe,
                           input bit has_fixed, input int code, input int alpha_code);
        request_t req;
        req.px.red_linear   = 16'(r);
        req.px.green_linear = 16'(g);
        req.px.blue_linear  = 16'(b);
        req.px.alpha_linear = 16'(a);
        req.px.frame_end_in = fe;
        req.has_fixed       = has_fixed;
        req.fixed_out.red_srgb      = 8'(code);
        req.fixed_out.green_srgb    = 8'(code);
        req.fixed_out.blue_srgb     = 8'(code);
        req.fixed_out.alpha_byte    = 8'(alpha_code);
        req.fixed_out.frame_end_out = fe;
        requests.push_back(req);
    endtask

    function automatic bit idle_now(input int n);
        if (n >= QUIET_LO && n < QUIET_HI)
            return 0;
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    // Send side: advance when the current request moves or none is held.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            linear_valid <= 1'b0;
            linear_pixel <= '0;
        end
        else
        begin
            if (linear_valid && !linear_stall)
            begin
                pending_pixels.push_back(cur_req.has_fixed ? cur_req.fixed_out
                                         : unpremultiply_encode(cur_req.px));
                accepted_cnt++;
            end
            if (!linear_valid || !linear_stall)
            begin
                if (next_req < requests.size() && !idle_now(next_req))
                begin
                    cur_req = requests[next_req];
                    next_req++;
                    linear_pixel <= cur_req.px;
                    linear_valid <= 1'b1;
                end
                else
                    linear_valid <= 1'b0;
            end
        end
    end

    // Receive side.
    always @(posedge clk or negedge rst_n)
    begin
        srgb_pixel_t want;
        if (!rst_n)
            srgb_stall <= 1'b0;
        else
        begin
            if (srgb_valid && !srgb_stall)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $display("unexpected pixel %0d from the converter", out_cnt);
                    errors++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (srgb_pixel.red_srgb !== want.red_srgb)
                        report_mismatch("red", int'(srgb_pixel.red_srgb),
                                        int'(want.red_srgb));
                    if (srgb_pixel.green_srgb !== want.green_srgb)
                        report_mismatch("green", int'(srgb_pixel.green_srgb),
                                        int'(want.green_srgb));
                    if (srgb_pixel.blue_srgb !== want.blue_srgb)
                        report_mismatch("blue", int'(srgb_pixel.blue_srgb),
                                        int'(want.blue_srgb));
                    if (srgb_pixel.alpha_byte !== want.alpha_byte)
                        report_mismatch("alpha", int'(srgb_pixel.alpha_byte),
                                        int'(want.alpha_byte));
                    if (srgb_pixel.frame_end_out !== want.frame_end_out)
                        report_mismatch("frame_end", int'(srgb_pixel.frame_end_out),
                                        int'(want.frame_end_out));
                end
                out_cnt++;
            end
            srgb_stall <= idle_now(out_cnt);
        end
    end

    always @(posedge clk)
    begin
        if ((linear_valid && !linear_stall) || (srgb_valid && !srgb_stall) || !rst_n)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int a;
        clk   = 1'b0;
        rst_n = 1'b0;

        for (int i = 0; i < DIRECTED_ROWS; i++)
            add_row(DIRECTED[i].r, DIRECTED[i].g, DIRECTED[i].b, DIRECTED[i].a,
                    DIRECTED[i].fe, DIRECTED[i].has_fixed, DIRECTED[i].code,
                    DIRECTED[i].alpha_code);

        // Mostly well-formed pixels (0 <= color <= alpha <= 1), some raw noise.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(99) < 70)
            begin
                a = $urandom_range(ONE);
                add_row($urandom_range(a), $urandom_range(a), $urandom_range(a), a,
                        1'($urandom_range(1)), 0, 0, 0);
            end
            else
                add_row($urandom, $urandom, $urandom, $urandom,
                        1'($urandom_range(1)), 0, 0, 0);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        wait (next_req == requests.size() && !(linear_valid && linear_stall)
              && accepted_cnt == requests.size() && pending_pixels.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
